### src/scq_pkg.sv
package scq_pkg;

  // Queue and key table dimensions.
  localparam int QUEUE_DEPTH = 128;
  localparam int MAP_STRIDE  = 96;
  localparam int TABLE_DEPTH = 512;

  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int TAW    = $clog2(TABLE_DEPTH);

  // Lookup index must hold the caps section offset plus a 7-bit make code.
  localparam int LKP_RAW_W = $clog2(2 * MAP_STRIDE + 128);
  localparam int IDX_W     = (LKP_RAW_W > TAW) ? LKP_RAW_W : TAW;

  // Field widths of the interface.
  localparam int CODE_W   = 7;
  localparam int SC_W     = 8;
  localparam int KC_W     = 8;
  localparam int TI_W     = 9;
  localparam int FLAGS_W  = 5;
  localparam int ENTRY_W  = KC_W + SC_W + FLAGS_W;
  localparam int CFG_IDX_W = 3;
  localparam int OUT_CNT_W = 8;

  // Modifier flag bit positions.
  localparam int FLAG_SHIFT   = 0;
  localparam int FLAG_CONTROL = 1;
  localparam int FLAG_ALT     = 2;
  localparam int FLAG_CAPS    = 3;
  localparam int FLAG_EXT     = 4;

  localparam logic [SC_W-1:0] SC_PREFIX_EXT = 8'hE0;
  localparam logic [KC_W-1:0] KC_EMPTY      = 8'hFF;

  typedef enum logic [1:0] {
    CMD_SCAN  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    STAT_QUEUED   = 3'd0,
    STAT_CONSUMED = 3'd1,
    STAT_DROPPED  = 3'd2,
    STAT_READ_OK  = 3'd3,
    STAT_EMPTY    = 3'd4,
    STAT_DONE     = 3'd5
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LSHIFT = 3'd0,
    REG_RSHIFT = 3'd1,
    REG_CTRL   = 3'd2,
    REG_ALT    = 3'd3,
    REG_CAPS   = 3'd4
  } reg_idx_t;

  localparam logic [CODE_W-1:0] RST_LSHIFT = 7'd42;
  localparam logic [CODE_W-1:0] RST_RSHIFT = 7'd54;
  localparam logic [CODE_W-1:0] RST_CTRL   = 7'd29;
  localparam logic [CODE_W-1:0] RST_ALT    = 7'd56;
  localparam logic [CODE_W-1:0] RST_CAPS   = 7'd58;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic sweep;   // write one zero entry of the key table
    logic accept;  // capture the item and start memory reads
    logic commit;  // apply the item and load the output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic sweep_last;
  } dp_status_t;

endpackage

### src/scq_ctrl.sv
module scq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  output logic                m_tvalid,
  input  logic                m_tready,
  input  scq_pkg::dp_status_t stat,
  output scq_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    s_tready   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // The item takes effect only once the output register can take its result.
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

### src/scq_datapath.sv
module scq_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  scq_pkg::ctrl_cmd_t                  cmd,
  output scq_pkg::dp_status_t                 stat,
  input  logic                                cfg_we,
  input  logic [scq_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [scq_pkg::CODE_W-1:0]          cfg_data,
  input  logic [1:0]                          in_command,
  input  logic [scq_pkg::SC_W-1:0]            in_scancode,
  input  logic [scq_pkg::TI_W-1:0]            in_table_index,
  input  logic [scq_pkg::KC_W-1:0]            in_table_value,
  output logic [2:0]                          out_status,
  output logic [scq_pkg::ENTRY_W-1:0]         out_entry,
  output logic [scq_pkg::OUT_CNT_W-1:0]       out_count
);

  // Configuration registers.
  logic [scq_pkg::CODE_W-1:0] lshift_code, rshift_code, control_code, alt_code, caps_code;

  // Modifier state and queue bookkeeping.
  logic [scq_pkg::FLAGS_W-1:0] flags, flags_next;
  logic [scq_pkg::QPTR_W-1:0]  rd_ptr, rd_ptr_next, wr_ptr, wr_ptr_next;
  logic [scq_pkg::QCNT_W-1:0]  count, count_next;
  logic [scq_pkg::TAW-1:0]     sweep_addr;

  // Captured item.
  scq_pkg::cmd_t               cmd_r;
  logic [scq_pkg::SC_W-1:0]    sc_r;
  logic [scq_pkg::TI_W-1:0]    ti_r;
  logic [scq_pkg::KC_W-1:0]    tv_r;
  logic                        idx_ok_r;

  // Memories and their registered read data.
  logic [scq_pkg::KC_W-1:0]    key_table [scq_pkg::TABLE_DEPTH];
  logic [scq_pkg::ENTRY_W-1:0] queue_store [scq_pkg::QUEUE_DEPTH];
  logic [scq_pkg::KC_W-1:0]    tbl_rdata;
  logic [scq_pkg::ENTRY_W-1:0] q_rdata;

  logic [scq_pkg::IDX_W-1:0]   lkp_idx;
  logic                        tbl_we, tbl_we_cmd, q_we;
  logic [scq_pkg::TAW-1:0]     tbl_waddr;
  logic [scq_pkg::KC_W-1:0]    tbl_wdata;
  logic [scq_pkg::ENTRY_W-1:0] entry;
  scq_pkg::status_t            status;

  assign stat.sweep_last = (sweep_addr == scq_pkg::TAW'(scq_pkg::TABLE_DEPTH - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      lshift_code  <= scq_pkg::RST_LSHIFT;
      rshift_code  <= scq_pkg::RST_RSHIFT;
      control_code <= scq_pkg::RST_CTRL;
      alt_code     <= scq_pkg::RST_ALT;
      caps_code    <= scq_pkg::RST_CAPS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        scq_pkg::REG_LSHIFT: lshift_code  <= cfg_data;
        scq_pkg::REG_RSHIFT: rshift_code  <= cfg_data;
        scq_pkg::REG_CTRL:   control_code <= cfg_data;
        scq_pkg::REG_ALT:    alt_code     <= cfg_data;
        scq_pkg::REG_CAPS:   caps_code    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Section select: shift alone picks the shift section, caps lock alone the caps section.
  always_comb begin
    lkp_idx = scq_pkg::IDX_W'(in_scancode[scq_pkg::CODE_W-1:0]);
    if (flags[scq_pkg::FLAG_SHIFT] && !flags[scq_pkg::FLAG_CAPS]) begin
      lkp_idx = lkp_idx + scq_pkg::IDX_W'(scq_pkg::MAP_STRIDE);
    end else if (!flags[scq_pkg::FLAG_SHIFT] && flags[scq_pkg::FLAG_CAPS]) begin
      lkp_idx = lkp_idx + scq_pkg::IDX_W'(2 * scq_pkg::MAP_STRIDE);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_r    <= scq_pkg::cmd_t'(in_command);
      sc_r     <= in_scancode;
      ti_r     <= in_table_index;
      tv_r     <= in_table_value;
      idx_ok_r <= (32'(lkp_idx) < scq_pkg::TABLE_DEPTH);
    end
  end

  // Result of the captured item, applied on commit.
  always_comb begin
    flags_next  = flags;
    rd_ptr_next = rd_ptr;
    wr_ptr_next = wr_ptr;
    count_next  = count;
    status      = scq_pkg::STAT_DONE;
    entry       = '0;
    q_we        = 1'b0;
    tbl_we_cmd  = 1'b0;
    unique case (cmd_r)
      scq_pkg::CMD_SCAN: begin
        status = scq_pkg::STAT_CONSUMED;
        if (sc_r[scq_pkg::SC_W-1]) begin
          if (sc_r == {1'b1, lshift_code} || sc_r == {1'b1, rshift_code}) begin
            flags_next[scq_pkg::FLAG_SHIFT] = 1'b0;
          end else if (sc_r == {1'b1, control_code}) begin
            flags_next[scq_pkg::FLAG_CONTROL] = 1'b0;
          end else if (sc_r == {1'b1, alt_code}) begin
            flags_next[scq_pkg::FLAG_ALT] = 1'b0;
          end else if (sc_r == scq_pkg::SC_PREFIX_EXT) begin
            flags_next[scq_pkg::FLAG_EXT] = 1'b1;
          end else begin
            flags_next[scq_pkg::FLAG_EXT] = 1'b0;
          end
        end else if (sc_r[scq_pkg::CODE_W-1:0] == lshift_code ||
                     sc_r[scq_pkg::CODE_W-1:0] == rshift_code) begin
          flags_next[scq_pkg::FLAG_SHIFT] = 1'b1;
        end else if (sc_r[scq_pkg::CODE_W-1:0] == control_code) begin
          flags_next[scq_pkg::FLAG_CONTROL] = 1'b1;
        end else if (sc_r[scq_pkg::CODE_W-1:0] == alt_code) begin
          flags_next[scq_pkg::FLAG_ALT] = 1'b1;
        end else if (sc_r[scq_pkg::CODE_W-1:0] == caps_code) begin
          flags_next[scq_pkg::FLAG_CAPS] = !flags[scq_pkg::FLAG_CAPS];
        end else begin
          entry = {flags, sc_r, idx_ok_r ? tbl_rdata : '0};
          if (count == scq_pkg::QCNT_W'(scq_pkg::QUEUE_DEPTH)) begin
            status = scq_pkg::STAT_DROPPED;
          end else begin
            status      = scq_pkg::STAT_QUEUED;
            q_we        = 1'b1;
            wr_ptr_next = (wr_ptr == scq_pkg::QPTR_W'(scq_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr + 1'b1;
            count_next  = count + 1'b1;
          end
          // The extended prefix applies to one lookup only, queued or dropped.
          flags_next[scq_pkg::FLAG_EXT] = 1'b0;
        end
      end
      scq_pkg::CMD_READ: begin
        if (count == '0) begin
          status = scq_pkg::STAT_EMPTY;
          entry  = scq_pkg::ENTRY_W'(scq_pkg::KC_EMPTY);
        end else begin
          status      = scq_pkg::STAT_READ_OK;
          entry       = q_rdata;
          rd_ptr_next = (rd_ptr == scq_pkg::QPTR_W'(scq_pkg::QUEUE_DEPTH - 1)) ?
                        '0 : rd_ptr + 1'b1;
          count_next  = count - 1'b1;
        end
      end
      scq_pkg::CMD_WRITE: begin
        tbl_we_cmd = (32'(ti_r) < scq_pkg::TABLE_DEPTH);
      end
      scq_pkg::CMD_CLEAR: begin
        rd_ptr_next = '0;
        wr_ptr_next = '0;
        count_next  = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags      <= '0;
      rd_ptr     <= '0;
      wr_ptr     <= '0;
      count      <= '0;
      sweep_addr <= '0;
    end else begin
      if (cmd.sweep) begin
        sweep_addr <= sweep_addr + 1'b1;
      end
      if (cmd.commit) begin
        flags  <= flags_next;
        rd_ptr <= rd_ptr_next;
        wr_ptr <= wr_ptr_next;
        count  <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status <= status;
      out_entry  <= entry;
      out_count  <= scq_pkg::OUT_CNT_W'(count_next);
    end
  end

  // Key table: zeroed by the sweep after reset, then written by table commands.
  assign tbl_we    = cmd.sweep || (cmd.commit && tbl_we_cmd);
  assign tbl_waddr = cmd.sweep ? sweep_addr : scq_pkg::TAW'(ti_r);
  assign tbl_wdata = cmd.sweep ? '0 : tv_r;

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      key_table[tbl_waddr] <= tbl_wdata;
    end
    if (cmd.accept) begin
      tbl_rdata <= key_table[scq_pkg::TAW'(lkp_idx)];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && q_we) begin
      queue_store[wr_ptr] <= entry;
    end
    if (cmd.accept) begin
      q_rdata <= queue_store[rd_ptr];
    end
  end

endmodule

### src/scancode_to_keycode_queue.sv
// An accepted item is captured together with its key table and queue reads, then
// applied in the execute state, which loads the result and raises m_tvalid; that
// state waits while the previous result has not been taken. s_tready is low meanwhile,
// so a new item is taken only once the current one has been applied.
// Reset: state, pointers, flags and configuration registers clear at once; the key table is then zeroed
// by a sweep over all TABLE_DEPTH (512) entries with s_tready low. Configuration writes are taken always.
module scancode_to_keycode_queue (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // scancode[7:0], table_index[16:8], table_value[24:17]
  input  logic [1:0]  s_tuser,   // command[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // keycode[7:0], entry_scancode[15:8], entry_shift[16],
                                 // entry_control[17], entry_alt[18], entry_capslock[19],
                                 // entry_extended[20], queue_count[28:21]
  output logic [2:0]  m_tuser,   // status[2:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [6:0]  cfg_data
);

  scq_pkg::ctrl_cmd_t                  cmd;
  scq_pkg::dp_status_t                 stat;
  logic [scq_pkg::ENTRY_W-1:0]         out_entry;
  logic [scq_pkg::OUT_CNT_W-1:0]       out_count;

  assign cfg_ready = 1'b1;

  scq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  scq_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_command     (s_tuser),
    .in_scancode    (s_tdata[7:0]),
    .in_table_index (s_tdata[16:8]),
    .in_table_value (s_tdata[24:17]),
    .out_status     (m_tuser),
    .out_entry      (out_entry),
    .out_count      (out_count)
  );

  assign m_tdata = {3'b000, out_count, out_entry};

endmodule
